// ===== rtl/cbpa_pkg.sv =====
// Shared types and constants of the chained bump pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package cbpa_pkg;

    localparam int MAX_BLOCKS_DEF  = 16;
    localparam int OFFSET_BITS_DEF = 16;

    localparam int CMD_W      = 2;
    localparam int SIZE_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int INDEX_W    = 4;
    localparam int OFFSET_W   = 16;
    localparam int COUNT_W    = 5;
    localparam int FAIL_W     = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    localparam logic [SIZE_W-1:0] USABLE_RESET = 16'd4096;

    localparam logic [FAIL_W-1:0] FAIL_LIMIT = 3'd4;
    localparam logic [FAIL_W-1:0] FAIL_MAX   = 3'd7;

    localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REWIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECREATE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_BLOCK  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FAIL_RD,
        S_FAIL_WR,
        S_APPEND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  block_index;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  blocks_in_use;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/cbpa_ram.sv =====
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/cbpa_alu.sv =====
// Shared fit test, bump adder and failure count update.
`timescale 1ns / 1ps
`default_nettype none

module cbpa_alu #(
    parameter int FW = cbpa_pkg::OFFSET_BITS_DEF
) (
    input  wire logic [FW-1:0]               i_fill,
    input  wire logic [cbpa_pkg::SIZE_W-1:0] i_size,
    input  wire logic [cbpa_pkg::SIZE_W-1:0] i_usable,
    input  wire logic [cbpa_pkg::FAIL_W-1:0] i_fail,
    output logic                             o_fit,
    output logic      [FW-1:0]               o_sum,
    output logic      [cbpa_pkg::FAIL_W-1:0] o_fail_next,
    output logic                             o_fail_over
);
    import cbpa_pkg::*;

    localparam int SW = ((FW > SIZE_W) ? FW : SIZE_W) + 1;

    logic [SW-1:0] w_sum;

    // The block has room exactly when the bumped fill stays below capacity.
    assign w_sum       = SW'(i_fill) + SW'(i_size);
    assign o_fit       = w_sum < SW'(i_usable);
    assign o_sum       = w_sum[FW-1:0];
    assign o_fail_over = i_fail > FAIL_LIMIT;
    assign o_fail_next = (i_fail < FAIL_MAX) ? i_fail + 3'd1 : FAIL_MAX;

endmodule

`default_nettype wire

// ===== rtl/cbpa_seq.sv =====
// Command sequencer that walks the block table through the shared unit.
`timescale 1ns / 1ps
`default_nettype none

module cbpa_seq #(
    parameter int MAX_BLOCKS  = cbpa_pkg::MAX_BLOCKS_DEF,
    parameter int OFFSET_BITS = cbpa_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [cbpa_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [cbpa_pkg::SIZE_W-1:0] i_size,
    input  wire logic [cbpa_pkg::SIZE_W-1:0] i_usable,
    output logic                          o_ready,
    output logic                          o_res_valid,
    input  wire logic                     i_res_take,
    output cbpa_pkg::t_result             o_res
);
    import cbpa_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int FW = OFFSET_BITS;
    localparam int RW = FW + FAIL_W;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_cur, n_cur;
    logic [IW-1:0]     r_cur_new, n_cur_new;
    logic [CW-1:0]     r_count, n_count;
    logic              r_report, n_report;
    logic [SIZE_W-1:0] r_size, n_size;
    t_result           r_res, n_res;

    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [RW-1:0]     w_wdata;
    logic [RW-1:0]     w_rdata;
    logic [FW-1:0]     w_rd_fill;
    logic [FAIL_W-1:0] w_rd_fail;

    logic [FW-1:0]     w_alu_fill;
    logic [SIZE_W-1:0] w_alu_size;
    logic              w_fit;
    logic [FW-1:0]     w_sum;
    logic [FAIL_W-1:0] w_fail_next;
    logic              w_fail_over;

    logic [CW:0]       w_idx_p1;
    logic [CW:0]       w_idx_p2;
    logic [CW:0]       w_cur_p1;
    logic [CW:0]       w_count_x;

    assign w_rd_fill = w_rdata[FW-1:0];
    assign w_rd_fail = w_rdata[RW-1:FW];
    assign w_idx_p1  = (CW+1)'(r_idx) + (CW+1)'(1);
    assign w_idx_p2  = (CW+1)'(r_idx) + (CW+1)'(2);
    assign w_cur_p1  = (CW+1)'(r_cur) + (CW+1)'(1);
    assign w_count_x = (CW+1)'(r_count);

    cbpa_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    cbpa_alu #(
        .FW (FW)
    ) u_alu (
        .i_fill      (w_alu_fill),
        .i_size      (w_alu_size),
        .i_usable    (i_usable),
        .i_fail      (w_rd_fail),
        .o_fit       (w_fit),
        .o_sum       (w_sum),
        .o_fail_next (w_fail_next),
        .o_fail_over (w_fail_over)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_cur    <= '0;
            r_count  <= CW'(1);
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_cur    <= n_cur;
            r_count  <= n_count;
            r_report <= n_report;
        end
        r_cur_new <= n_cur_new;
        r_size    <= n_size;
        r_res     <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_cur_new   = r_cur_new;
        n_count     = r_count;
        n_report    = r_report;
        n_size      = r_size;
        n_res       = r_res;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = '0;
        w_alu_fill  = '0;
        w_alu_size  = r_size;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                if (w_idx_p1 >= w_count_x) begin
                    n_idx   = '0;
                    n_state = r_report ? S_DONE : S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_IDLE: begin
                o_ready    = 1'b1;
                w_alu_size = i_size;
                if (i_start) begin
                    n_size   = i_size;
                    n_report = 1'b1;
                    n_res    = '{status: STAT_OK, block_index: '0, offset: '0,
                                 blocks_in_use: '0};
                    priority case (i_cmd)
                        CMD_ALLOC: begin
                            if (!w_fit) begin
                                n_res.status = STAT_TOO_LARGE;
                                n_state      = S_DONE;
                            end else begin
                                n_idx   = r_cur;
                                n_state = S_SCAN_RD;
                            end
                        end
                        CMD_REWIND: begin
                            n_cur   = '0;
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        CMD_RECREATE: begin
                            n_count = CW'(1);
                            n_cur   = '0;
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                w_alu_fill = w_rd_fill;
                if (w_fit) begin
                    w_we              = 1'b1;
                    w_wdata           = {w_rd_fail, w_sum};
                    n_res.block_index = INDEX_W'(r_idx);
                    n_res.offset      = OFFSET_W'(w_rd_fill);
                    n_state           = S_DONE;
                end else if (w_idx_p1 < w_count_x) begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_SCAN_RD;
                end else if (w_count_x >= (CW+1)'(MAX_BLOCKS)) begin
                    n_res.status = STAT_NO_BLOCK;
                    n_state      = S_DONE;
                end else begin
                    n_cur_new = r_cur;
                    n_idx     = r_cur;
                    n_state   = (w_cur_p1 < w_count_x) ? S_FAIL_RD : S_APPEND;
                end
            end
            S_FAIL_RD: begin
                n_state = S_FAIL_WR;
            end
            S_FAIL_WR: begin
                w_we    = 1'b1;
                w_wdata = {w_fail_next, w_rd_fill};
                if (w_fail_over) begin
                    n_cur_new = r_idx + IW'(1);
                end
                if (w_idx_p2 < w_count_x) begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_FAIL_RD;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                w_we              = 1'b1;
                w_waddr           = IW'(r_count);
                w_wdata           = {FAIL_W'(0), w_sum};
                n_res.block_index = INDEX_W'(r_count);
                n_res.offset      = '0;
                n_count           = r_count + CW'(1);
                n_cur             = r_cur_new;
                n_state           = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res               = r_res;
        o_res.blocks_in_use = COUNT_W'(r_count);
    end

endmodule

`default_nettype wire

// ===== rtl/chained_bump_pool_allocator_top.sv =====
// Top level of the chained bump pool allocator with config register and output word.
//
// Channel   Dir  tdata                   tuser
// s_axis    in   [15:0] alloc_size       [1:0] command
// m_axis    out  [3:0] block_index,      [1:0] status
//                [19:4] offset, [24:20] blocks_in_use
// cfg       in   i_cfg_wr_data = usable_bytes, written when i_cfg_wr_en is high
//
// An allocate reads and then checks each block scanned from the current block, reads and
// then writes each block whose failure count is raised, and may append a block at the end;
// the block table RAM with its registered read port splits each block step into a read and a
// check or write. Rewind clears every block in use, recreate clears the first entry only.
// After reset the sequencer clears the first table entry before the first word is accepted.
// A result word waits in the output register while the next word is accepted; while that
// register is full and stalled, the sequencer holds its result and accepts no word.
`timescale 1ns / 1ps
`default_nettype none

module chained_bump_pool_allocator_top #(
    parameter int MAX_BLOCKS  = cbpa_pkg::MAX_BLOCKS_DEF,
    parameter int OFFSET_BITS = cbpa_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [cbpa_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [15:0] alloc_size
    input  wire logic [cbpa_pkg::CMD_W-1:0]      s_axis_tuser,  // [1:0] command
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [cbpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // block_index, offset, blocks_in_use
    output logic      [cbpa_pkg::STATUS_W-1:0]   m_axis_tuser,  // [1:0] status
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [cbpa_pkg::SIZE_W-1:0]     i_cfg_wr_data
);
    import cbpa_pkg::*;

    logic [SIZE_W-1:0] r_usable;
    logic              r_out_valid, n_out_valid;
    t_result           r_out;
    logic              w_ready;
    logic              w_res_valid;
    logic              w_take;
    t_result           w_res;

    cbpa_seq #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_axis_tvalid & w_ready),
        .i_cmd       (s_axis_tuser),
        .i_size      (s_axis_tdata[SIZE_W-1:0]),
        .i_usable    (r_usable),
        .o_ready     (w_ready),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_take),
        .o_res       (w_res)
    );

    assign w_take      = w_res_valid & (~r_out_valid | m_axis_tready);
    assign n_out_valid = w_take | (r_out_valid & ~m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable    <= USABLE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_usable <= i_cfg_wr_data;
            end
            r_out_valid <= n_out_valid;
        end
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign s_axis_tready = w_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = OUT_DATA_W'({r_out.blocks_in_use, r_out.offset, r_out.block_index});

endmodule

`default_nettype wire

// ===== rtl/cbpa_checker.sv =====
// Port level checks of the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cbpa_checker #(
    parameter int MAX_BLOCKS = cbpa_pkg::MAX_BLOCKS_DEF
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [cbpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [cbpa_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import cbpa_pkg::*;

    // No result word is shown in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    // A stalled result word holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    // A refused request reports no block and no offset.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata[19:0] == 20'd0)
        else $error("refused request carries a region");

    // The chain always holds at least one and at most the maximum number of blocks.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[24:20] != 5'd0 &&
            32'(m_axis_tdata[24:20]) <= 32'(MAX_BLOCKS))
        else $error("block count out of range");

    // Results only ever carry the three defined status codes.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser == STAT_OK || m_axis_tuser == STAT_TOO_LARGE ||
            m_axis_tuser == STAT_NO_BLOCK)
        else $error("undefined status code");

endmodule

bind chained_bump_pool_allocator_top cbpa_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_cbpa_checker (.*);

`default_nettype wire
